### rtl/rotated_box_bounds_macros.svh
// ----------------------------------------------------------------------------
// rotated_box_bounds_macros.svh
// Assertion macros for the rotated box bounds block.
// ----------------------------------------------------------------------------
`ifndef ROTATED_BOX_BOUNDS_MACROS_SVH
`define ROTATED_BOX_BOUNDS_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked in the cycle after the antecedent, also during reset.
`define RBB_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error("assertion failed");
// Checked in the cycle after the antecedent, off during reset.
`define RBB_ASSERT_NEXT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define RBB_ASSERT_NEXT(lbl, pre, post)
`define RBB_ASSERT_NEXT_RST(lbl, pre, post)
`endif

`endif

### rtl/rbb_pkg.sv
// ----------------------------------------------------------------------------
// rbb_pkg
// Types, constants and the arctangent table shared by the bounds pipeline.
// ----------------------------------------------------------------------------
package rbb_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam int CW           = 34;   // CORDIC datapath width
  localparam int HW_W         = 27;   // half extent width, Q19.8 unsigned

  localparam logic [15:0]          SCALE_RESET  = 16'd256;
  localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [16:0]   FULL_TURN    = 17'sd23040;
  localparam logic signed [16:0]   HALF_TURN    = 17'sd11520;
  localparam logic signed [16:0]   QUARTER_TURN = 17'sd5760;

  // Sideband that travels alongside the CORDIC values.
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [HW_W-1:0]    hw;
    logic [HW_W-1:0]    hh;
    logic               neg;
  } rbb_side_t;

  // atan(2^-i) in units of 2^-24 degree.
  function automatic logic signed [CW-1:0] atan_val(input int idx);
    logic signed [CW-1:0] v;
    case (idx)
      0:  v = 34'sd754974720;
      1:  v = 34'sd445687602;
      2:  v = 34'sd235489088;
      3:  v = 34'sd119537938;
      4:  v = 34'sd60000934;
      5:  v = 34'sd30029717;
      6:  v = 34'sd15018523;
      7:  v = 34'sd7509720;
      8:  v = 34'sd3754917;
      9:  v = 34'sd1877466;
      10: v = 34'sd938734;
      11: v = 34'sd469367;
      12: v = 34'sd234684;
      13: v = 34'sd117342;
      14: v = 34'sd58671;
      15: v = 34'sd29335;
      16: v = 34'sd14668;
      17: v = 34'sd7334;
      18: v = 34'sd3667;
      19: v = 34'sd1833;
      20: v = 34'sd917;
      21: v = 34'sd458;
      22: v = 34'sd229;
      23: v = 34'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/rbb_if.sv
// ----------------------------------------------------------------------------
// rbb_if
// Valid/ready channels for sprite beats, bound beats and the scale register.
// ----------------------------------------------------------------------------
interface rbb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic [11:0]        tex_width;
  logic [11:0]        tex_height;
  logic signed [15:0] rot_angle;
  modport source (output valid, center_x, center_y, tex_width, tex_height, rot_angle,
                  input ready);
  modport sink (input valid, center_x, center_y, tex_width, tex_height, rot_angle,
                output ready);
endinterface

interface rbb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] min_x;
  logic signed [31:0] min_y;
  logic signed [31:0] max_x;
  logic signed [31:0] max_y;
  modport source (output valid, min_x, min_y, max_x, max_y, input ready);
  modport sink (input valid, min_x, min_y, max_x, max_y, output ready);
endinterface

interface rbb_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] sprite_scale;
  modport source (output valid, sprite_scale, input ready);
  modport sink (input valid, sprite_scale, output ready);
endinterface

### rtl/rbb_cordic_cell.sv
// ----------------------------------------------------------------------------
// rbb_cordic_cell
// One rotation-mode CORDIC iteration with its register and sideband.
// ----------------------------------------------------------------------------
module rbb_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          v_in,
  input  logic signed [rbb_pkg::CW-1:0] x_in,
  input  logic signed [rbb_pkg::CW-1:0] y_in,
  input  logic signed [rbb_pkg::CW-1:0] z_in,
  input  rbb_pkg::rbb_side_t            side_in,
  output logic                          v_out,
  output logic signed [rbb_pkg::CW-1:0] x_out,
  output logic signed [rbb_pkg::CW-1:0] y_out,
  output logic signed [rbb_pkg::CW-1:0] z_out,
  output rbb_pkg::rbb_side_t            side_out
);
  import rbb_pkg::*;

  localparam logic signed [CW-1:0] ATAN = atan_val(IDX);

  logic signed [CW-1:0] xs, ys, x_nxt, y_nxt, z_nxt;
  logic                 v_r;
  logic signed [CW-1:0] x_r, y_r, z_r;
  rbb_side_t            side_r;

  assign xs = x_in >>> IDX;
  assign ys = y_in >>> IDX;

  always_comb begin
    if (!z_in[CW-1]) begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ATAN;
    end else begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_in;
    end
  end

  assign v_out    = v_r;
  assign x_out    = x_r;
  assign y_out    = y_r;
  assign z_out    = z_r;
  assign side_out = side_r;

endmodule

### rtl/rotated_box_bounds.sv
// ----------------------------------------------------------------------------
// rotated_box_bounds
// Axis-aligned bounds of a scaled sprite rectangle rotated about its center.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  in_bus    sink       center_x, center_y, tex_width, tex_height, rot_angle
//  out_bus   source     min_x, min_y, max_x, max_y
//  cfg_bus   sink       sprite_scale (always ready)
//
//  One beat per cycle while the output is not stalled; registers are the input
//  register, one cell per CORDIC iteration, multiply, corner sums, min/max and clamp.
//  Reset sets the scale to 1.0 and empties the pipeline.
//  A stalled output beat holds the whole pipeline; in_bus.ready follows it.
// ----------------------------------------------------------------------------
`include "rotated_box_bounds_macros.svh"

module rotated_box_bounds #(
  parameter int CORDIC_STAGES = 16
) (
  input logic   clk,
  input logic   rst_n,
  rbb_in_if.sink    in_bus,
  rbb_out_if.source out_bus,
  rbb_cfg_if.sink   cfg_bus
);
  import rbb_pkg::*;

  localparam int NSTG = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int PW   = HW_W + 33;   // product width

  logic        en;
  logic [15:0] scale_r;

  assign en           = !out_bus.valid || out_bus.ready;
  assign in_bus.ready = en;
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_bus.valid) begin
      scale_r <= cfg_bus.sprite_scale;
    end
  end

  // Angle fold into [-90, 90] degrees and half extents.
  logic signed [16:0] ang_w, ang_f;
  logic               neg_nxt;
  logic [27:0]        wprod, hprod;

  always_comb begin
    ang_w = {in_bus.rot_angle[15], in_bus.rot_angle};
    if (ang_w >= HALF_TURN) begin
      ang_w = ang_w - FULL_TURN;
    end else if (ang_w < -HALF_TURN) begin
      ang_w = ang_w + FULL_TURN;
    end
    neg_nxt = 1'b0;
    ang_f   = ang_w;
    if (ang_w > QUARTER_TURN) begin
      ang_f   = ang_w - HALF_TURN;
      neg_nxt = 1'b1;
    end else if (ang_w < -QUARTER_TURN) begin
      ang_f   = ang_w + HALF_TURN;
      neg_nxt = 1'b1;
    end
  end

  assign wprod = 28'(in_bus.tex_width) * 28'(scale_r);
  assign hprod = 28'(in_bus.tex_height) * 28'(scale_r);

  logic                 v_c   [NSTG+1];
  logic signed [CW-1:0] x_c   [NSTG+1];
  logic signed [CW-1:0] y_c   [NSTG+1];
  logic signed [CW-1:0] z_c   [NSTG+1];
  rbb_side_t            side_c[NSTG+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c[0] <= 1'b0;
    end else if (en) begin
      v_c[0] <= in_bus.valid;
    end
    if (en) begin
      x_c[0]         <= CORDIC_GAIN;
      y_c[0]         <= '0;
      z_c[0]         <= CW'(ang_f) <<< 18;
      side_c[0].cx   <= in_bus.center_x;
      side_c[0].cy   <= in_bus.center_y;
      side_c[0].hw   <= wprod[27:1];
      side_c[0].hh   <= hprod[27:1];
      side_c[0].neg  <= neg_nxt;
    end
  end

  for (genvar g = 0; g < NSTG; g++) begin : g_cell
    rbb_cordic_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .v_in     (v_c[g]),
      .x_in     (x_c[g]),
      .y_in     (y_c[g]),
      .z_in     (z_c[g]),
      .side_in  (side_c[g]),
      .v_out    (v_c[g+1]),
      .x_out    (x_c[g+1]),
      .y_out    (y_c[g+1]),
      .z_out    (z_c[g+1]),
      .side_out (side_c[g+1])
    );
  end

  // Products of the half extents with cosine and sine.
  logic signed [31:0] cos_w, sin_w;
  logic signed [CW-1:0] xe, ye;
  rbb_side_t            se;

  assign xe    = x_c[NSTG];
  assign ye    = y_c[NSTG];
  assign se    = side_c[NSTG];
  assign cos_w = se.neg ? 32'(-xe) : xe[31:0];
  assign sin_w = se.neg ? 32'(-ye) : ye[31:0];

  logic                 v_m_r;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [31:0]   mcx_r, mcy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_m_r <= 1'b0;
    end else if (en) begin
      v_m_r <= v_c[NSTG];
    end
    if (en) begin
      pa_r  <= PW'($signed({1'b0, se.hw}) * cos_w);
      pb_r  <= PW'($signed({1'b0, se.hh}) * sin_w);
      pc_r  <= PW'($signed({1'b0, se.hw}) * sin_w);
      pd_r  <= PW'($signed({1'b0, se.hh}) * cos_w);
      mcx_r <= se.cx;
      mcy_r <= se.cy;
    end
  end

  // Corner offsets, rounding to Q24.8 and center offset.
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] HALF_LSB = SW'(1) <<< 29;

  function automatic logic signed [33:0] corner(input logic signed [SW-1:0] sum,
                                                input logic signed [31:0]   ctr);
    logic signed [SW-1:0] rs;
    rs = (sum + HALF_LSB) >>> 30;
    return 34'(rs) + 34'(ctr);
  endfunction

  logic signed [SW-1:0] sa, sb, sc, sd;
  assign sa = SW'(pa_r);
  assign sb = SW'(pb_r);
  assign sc = SW'(pc_r);
  assign sd = SW'(pd_r);

  logic               v_s_r;
  logic signed [33:0] px_r [4];
  logic signed [33:0] py_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s_r <= 1'b0;
    end else if (en) begin
      v_s_r <= v_m_r;
    end
    if (en) begin
      px_r[0] <= corner(-sa - sb, mcx_r);
      py_r[0] <= corner(-sc + sd, mcy_r);
      px_r[1] <= corner(sa - sb, mcx_r);
      py_r[1] <= corner(sc + sd, mcy_r);
      px_r[2] <= corner(sa + sb, mcx_r);
      py_r[2] <= corner(sc - sd, mcy_r);
      px_r[3] <= corner(-sa + sb, mcx_r);
      py_r[3] <= corner(-sc - sd, mcy_r);
    end
  end

  function automatic logic signed [33:0] min2(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic signed [33:0] max2(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    return (b > a) ? b : a;
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic               out_v_r;
  logic signed [31:0] min_x_r, min_y_r, max_x_r, max_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_s_r;
    end
    if (en) begin
      min_x_r <= sat(min2(min2(px_r[0], px_r[1]), min2(px_r[2], px_r[3])));
      max_x_r <= sat(max2(max2(px_r[0], px_r[1]), max2(px_r[2], px_r[3])));
      min_y_r <= sat(min2(min2(py_r[0], py_r[1]), min2(py_r[2], py_r[3])));
      max_y_r <= sat(max2(max2(py_r[0], py_r[1]), max2(py_r[2], py_r[3])));
    end
  end

  assign out_bus.valid = out_v_r;
  assign out_bus.min_x = min_x_r;
  assign out_bus.min_y = min_y_r;
  assign out_bus.max_x = max_x_r;
  assign out_bus.max_y = max_y_r;

  `RBB_ASSERT_NEXT(a_scale_reset, !rst_n, scale_r == SCALE_RESET)
  `RBB_ASSERT_NEXT_RST(a_out_hold, out_bus.valid && !out_bus.ready, out_bus.valid)
  `RBB_ASSERT_NEXT_RST(a_pipe_hold, !en, $stable(v_s_r) && $stable(v_m_r))
  `RBB_ASSERT_NEXT_RST(a_out_from_sum, en, out_bus.valid == $past(v_s_r))

endmodule

### bench/tb_checker.sv
// ----------------------------------------------------------------------------
// tb_checker
// Watches the sprite, bound and scale channels of rotated_box_bounds, predicts
// the bounding box of each accepted sprite beat and compares it with the
// bound beats in order.
// ----------------------------------------------------------------------------
module tb_checker (
  input  logic      clk,
  input  logic      rst_n,
  rbb_in_if         in_mon,
  rbb_out_if        out_mon,
  rbb_cfg_if        cfg_mon,
  output int        fail_count,
  output int        pending_boxes
);
  timeunit 1ns;
  timeprecision 1ps;

  import rbb_pkg::*;

  localparam int STAGES = 16;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
  } box_t;

  box_t        expected_boxes[$];
  logic [15:0] scale_q;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic box_t bounds_of(logic signed [31:0] cx, logic signed [31:0] cy,
                                     logic [11:0] tw, logic [11:0] th,
                                     logic signed [15:0] ang, logic [15:0] scale);
    longint r, x, y, z, xs, ys, hw, hh, dx, dy, px, py;
    longint mnx, mny, mxx, mxy;
    bit     flip;
    box_t   b;
    r = longint'(ang) % 23040;
    if (r < 0) r += 23040;
    if (r >= 11520) r -= 23040;
    flip = 0;
    if (r > 5760) begin
      r -= 11520;
      flip = 1;
    end else if (r < -5760) begin
      r += 11520;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    z = r * 262144;
    for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_val(i));
      end else begin
        x += ys; y -= xs; z += longint'(atan_val(i));
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    hw = (longint'(tw) * longint'(scale)) / 2;
    hh = (longint'(th) * longint'(scale)) / 2;
    mnx = 0; mny = 0; mxx = 0; mxy = 0;
    for (int k = 0; k < 4; k++) begin
      dx = (k == 0 || k == 3) ? -hw : hw;
      dy = (k < 2) ? hh : -hh;
      px = longint'(cx) + floor_shift(dx * x - dy * y + (64'sd1 <<< 29), 30);
      py = longint'(cy) + floor_shift(dx * y + dy * x + (64'sd1 <<< 29), 30);
      if (k == 0 || px < mnx) mnx = px;
      if (k == 0 || px > mxx) mxx = px;
      if (k == 0 || py < mny) mny = py;
      if (k == 0 || py > mxy) mxy = py;
    end
    b.min_x = clamp32(mnx);
    b.min_y = clamp32(mny);
    b.max_x = clamp32(mxx);
    b.max_y = clamp32(mxy);
    return b;
  endfunction

  assign pending_boxes = expected_boxes.size();

  always @(posedge clk) begin
    box_t want;
    if (!rst_n) begin
      scale_q <= SCALE_RESET;
      expected_boxes.delete();
      fail_count <= 0;
    end else begin
      // A scale write and a sprite beat in the same cycle: the beat uses the old scale.
      if (in_mon.valid && in_mon.ready)
        expected_boxes.push_back(bounds_of(in_mon.center_x, in_mon.center_y,
          in_mon.tex_width, in_mon.tex_height, in_mon.rot_angle, scale_q));
      if (cfg_mon.valid && cfg_mon.ready) scale_q <= cfg_mon.sprite_scale;
      if (out_mon.valid && out_mon.ready) begin
        if (expected_boxes.size() == 0) begin
          $error("bound beat with no sprite pending");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_boxes.pop_front();
          if (want.min_x !== out_mon.min_x || want.min_y !== out_mon.min_y ||
              want.max_x !== out_mon.max_x || want.max_y !== out_mon.max_y)
            fail_count <= fail_count + 1;
          if (want.min_x !== out_mon.min_x)
            $error("min_x: expected %0d, got %0d", want.min_x, out_mon.min_x);
          if (want.min_y !== out_mon.min_y)
            $error("min_y: expected %0d, got %0d", want.min_y, out_mon.min_y);
          if (want.max_x !== out_mon.max_x)
            $error("max_x: expected %0d, got %0d", want.max_x, out_mon.max_x);
          if (want.max_y !== out_mon.max_y)
            $error("max_y: expected %0d, got %0d", want.max_y, out_mon.max_y);
        end
      end
    end
  end
endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives sprite beats and scale writes into rotated_box_bounds with random
// gaps and back-pressure, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 16 + 4;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count;
  int   pending_boxes;
  bit   calm_phase = 0;
  bit   hold_off = 0;

  rbb_in_if  in_bus ();
  rbb_out_if out_bus ();
  rbb_cfg_if cfg_bus ();

  rotated_box_bounds u_top (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus), .cfg_bus(cfg_bus)
  );

  tb_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_bus), .out_mon(out_bus), .cfg_mon(cfg_bus),
    .fail_count(fail_count), .pending_boxes(pending_boxes)
  );

  always #5 clk = ~clk;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.center_x = 32'sd0;
    in_bus.center_y = 32'sd0;
    in_bus.tex_width = 12'd0;
    in_bus.tex_height = 12'd0;
    in_bus.rot_angle = 16'sd0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.sprite_scale = 16'd0;
  end

  // Bound-side back-pressure.
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_bus.ready <= 1'b0;
    else out_bus.ready <= calm_phase || ($urandom_range(99) >= 33);
  end

  // Valid stays high after the beat so that beats can follow back to back;
  // it drops only in an idle cycle or when the caller stops sending.
  task automatic send_sprite(logic signed [31:0] cx, logic signed [31:0] cy,
                             logic [11:0] tw, logic [11:0] th, logic signed [15:0] ang);
    while (!calm_phase && $urandom_range(99) < 33) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.center_x <= cx;
    in_bus.center_y <= cy;
    in_bus.tex_width <= tw;
    in_bus.tex_height <= th;
    in_bus.rot_angle <= ang;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic random_sprite();
    logic signed [31:0] cx, cy;
    logic [11:0]        tw, th;
    logic signed [15:0] ang;
    cx = $urandom;
    cy = $urandom;
    if ($urandom_range(3) != 0) begin
      cx = $signed(cx) >>> $urandom_range(31, 8);
      cy = $signed(cy) >>> $urandom_range(31, 8);
    end
    tw = 12'($urandom);
    th = 12'($urandom);
    case ($urandom_range(3))
      0: ang = 16'($urandom);
      1: ang = 16'($urandom_range(46080) - 23040);
      2: ang = 16'(5760 * $urandom_range(8)) - 16'sd23040 + 16'($urandom_range(2)) - 16'sd1;
      default: ang = 16'($urandom_range(720) - 360);
    endcase
    send_sprite(cx, cy, tw, th, ang);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_boxes != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_scale(logic [15:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.sprite_scale <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] scales[6];
    int          stretch;
    scales = '{16'd256, 16'd0, 16'd65535, 16'd1, 16'd512, 16'd128};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset scale.
    send_sprite(32'sd0, 32'sd0, 12'd0, 12'd0, 16'sd0);
    send_sprite(32'sh7fffffff, 32'sh80000000, 12'hfff, 12'hfff, 16'sd0);
    send_sprite(32'sh80000000, 32'sh7fffffff, 12'hfff, 12'hfff, 16'sd23040);
    send_sprite(32'sh7ffff000, -32'sh7ffff000, 12'hfff, 12'd1, -16'sd23040);
    send_sprite(1000, -1000, 12'd10, 12'd20, 16'sd5760);
    send_sprite(1000, -1000, 12'd10, 12'd20, 16'sd5761);
    send_sprite(1000, -1000, 12'd10, 12'd20, -16'sd5760);
    send_sprite(1000, -1000, 12'd10, 12'd20, -16'sd5761);
    send_sprite(0, 0, 12'd100, 12'd50, 16'sd11520);
    send_sprite(0, 0, 12'd100, 12'd50, -16'sd11520);
    send_sprite(0, 0, 12'd100, 12'd50, 16'sh7fff);
    send_sprite(0, 0, 12'd100, 12'd50, 16'sh8000);
    send_sprite(0, 0, 12'd100, 12'd50, 16'sd2880);
    send_sprite(12345, 678, 12'd0, 12'd77, 16'sd1000);
    send_sprite(-12345, 678, 12'd77, 12'd0, -16'sd1000);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_scale(scales[p]);
      calm_phase = (p == 2);
      if (p == 0) send_sprite(500, 500, 12'hfff, 12'hfff, 16'sd777);
      for (int n = 0; n < 250; n++) begin
        // One long bound-side stall while sprites keep coming.
        if (p == 1 && n == 20)
          fork
            begin
              hold_off = 1;
              stretch = 0;
              while (stretch < 200) begin
                @(posedge clk);
                stretch++;
              end
              hold_off = 0;
            end
          join_none
        random_sprite();
        // The sender waits here until every box is back.
        if (p == 3 && n == 100) begin
          in_bus.valid <= 1'b0;
          @(posedge clk);
          while (pending_boxes != 0) @(posedge clk);
        end
      end
      calm_phase = 0;
      drain();
    end
    write_scale(16'd256);
    for (int n = 0; n < 50; n++) random_sprite();
    drain();

    if (fail_count == 0) $display("rotated_box_bounds test passed");
    else $display("rotated_box_bounds test failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("rotated_box_bounds test failed");
    $finish;
  end
endmodule
